@@ design/mmp_pkg.sv @@
`default_nettype none
package mmp_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int WEIGHT_BITS = 16;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int CELL_AW = ROW_W + COL_W;
  localparam int COST_AW = ROW_W + 1;
  localparam int COST_W  = 21;
  localparam int CNT_W   = 6;

  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_DP      = 7'b0000010,
    S_MIN     = 7'b0000100,
    S_TRACE   = 7'b0001000,
    S_EMIT_RD = 7'b0010000,
    S_EMIT_LD = 7'b0100000,
    S_EMIT_WT = 7'b1000000
  } state_e;

  // load: take the operand as the running best; cmp: take it only if strictly lower
  typedef struct packed {
    logic load;
    logic cmp;
  } alu_ctl_t;

endpackage
`default_nettype wire

@@ design/matrix_min_path_wrap_dp.sv @@
// Loads one cell per cycle while in the load state; after the last cell, the DP reads, compares
// and adds the three predecessors of each cell of columns 1..C-1, then finds the final minimum,
// walks the traceback and emits each path row. One matrix of R*C cells at a time, paced by the
// shared compare/add unit and the single read port of the cost memory.
// Reset: num_rows = num_cols = 1, load position zero, no output pending.
// The memories are not cleared; every entry read is written first.
`default_nettype none
module matrix_min_path_wrap_dp (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // cell_weight[15:0]
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // path_row[4:0], total_cost[25:5], zero[31:26]
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mmp_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] last_col;

  logic [ROW_W-1:0] ld_row_q, ld_row_d, dr_q, dr_d, mr_q, mr_d, prow_q, prow_d;
  logic [COL_W-1:0] ld_col_q, ld_col_d, dc_q, dc_d, tc_q, tc_d, ec_q, ec_d;
  logic [2:0]       step_q, step_d;

  logic                     m_valid_q, m_valid_d, out_last_q, out_last_d;
  logic [ROW_W-1:0]         out_row_q, out_row_d;
  logic signed [COST_W-1:0] out_cost_q, out_cost_d;

  logic cfg_wr, in_acc;

  // memories
  logic                     w_we;
  logic [CELL_AW-1:0]       w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0]   w_rdata;
  logic                     c_we;
  logic [COST_AW-1:0]       c_waddr, c_raddr;
  logic [COST_W-1:0]        c_wdata, c_rdata;
  logic                     p_we;
  logic [ROW_W-1:0]         p_rdata;
  logic                     pb_we;
  logic [ROW_W-1:0]         pb_rdata;

  alu_ctl_t                 alu_ctl;
  logic [ROW_W-1:0]         alu_idx, best_idx;
  logic signed [COST_W-1:0] best_cost, alu_sum;

  logic [ROW_W-1:0] up_row, dn_row, cand0, cand1, cand2, cand_sel, t0, t1, t2, tmp;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = {{(32-CNT_W){1'b0}}, paddr[2] ? cols_q : rows_q};

  // zero counts as one, oversize counts as the maximum
  always_comb begin
    if (rows_q == '0) begin
      last_row = '0;
    end else if (rows_q > CNT_W'(MAX_ROWS)) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(rows_q - CNT_W'(1));
    end
    if (cols_q == '0) begin
      last_col = '0;
    end else if (cols_q > CNT_W'(MAX_COLS)) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(cols_q - CNT_W'(1));
    end
  end

  // three predecessor rows with wrap, sorted ascending so ties go to the lowest row
  always_comb begin
    tmp = '0;
    up_row = (dr_q == '0) ? last_row : dr_q - ROW_W'(1);
    dn_row = (dr_q == last_row) ? '0 : dr_q + ROW_W'(1);
    t0 = up_row;
    t1 = dr_q;
    t2 = dn_row;
    if (t0 > t1) begin
      tmp = t0; t0 = t1; t1 = tmp;
    end
    if (t1 > t2) begin
      tmp = t1; t1 = t2; t2 = tmp;
    end
    if (t0 > t1) begin
      tmp = t0; t0 = t1; t1 = tmp;
    end
    cand0 = t0;
    cand1 = t1;
    cand2 = t2;
    case (step_q)
      3'd0:    cand_sel = cand0;
      3'd1:    cand_sel = cand1;
      default: cand_sel = cand2;
    endcase
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign w_waddr = {ld_row_q, ld_col_q};
  assign w_raddr = {dr_q, dc_q};

  always_comb begin
    state_d    = state_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    ld_row_d   = ld_row_q;
    ld_col_d   = ld_col_q;
    dr_d       = dr_q;
    dc_d       = dc_q;
    mr_d       = mr_q;
    tc_d       = tc_q;
    ec_d       = ec_q;
    prow_d     = prow_q;
    step_d     = step_q;
    m_valid_d  = m_valid_q;
    out_last_d = out_last_q;
    out_row_d  = out_row_q;
    out_cost_d = out_cost_q;

    w_we    = 1'b0;
    c_we    = 1'b0;
    c_waddr = {1'b0, ld_row_q};
    c_wdata = {{(COST_W-WEIGHT_BITS){s_axis_tdata[WEIGHT_BITS-1]}}, s_axis_tdata};
    c_raddr = {~dc_q[0], cand_sel};
    p_we    = 1'b0;
    pb_we   = 1'b0;
    alu_ctl = '0;
    alu_idx = mr_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          w_we = 1'b1;
          // column 0 seeds the first cost column directly
          c_we = (ld_col_q == '0);
          if (ld_col_q == last_col) begin
            ld_col_d = '0;
            if (ld_row_q == last_row) begin
              ld_row_d = '0;
              dr_d     = '0;
              dc_d     = COL_W'(1);
              mr_d     = '0;
              step_d   = '0;
              state_d  = (last_col == '0) ? S_MIN : S_DP;
            end else begin
              ld_row_d = ld_row_q + ROW_W'(1);
            end
          end else begin
            ld_col_d = ld_col_q + COL_W'(1);
          end
        end
      end
      S_DP: begin
        // read cand k at step k, its data arrives at step k+1
        case (step_q)
          3'd1: begin
            alu_ctl.load = 1'b1;
            alu_idx      = cand0;
          end
          3'd2: begin
            alu_ctl.cmp = 1'b1;
            alu_idx     = cand1;
          end
          3'd3: begin
            alu_ctl.cmp = 1'b1;
            alu_idx     = cand2;
          end
          default: alu_idx = cand0;
        endcase
        if (step_q == 3'd4) begin
          c_we    = 1'b1;
          c_waddr = {dc_q[0], dr_q};
          c_wdata = alu_sum;
          p_we    = 1'b1;
          step_d  = '0;
          if (dr_q == last_row) begin
            dr_d = '0;
            if (dc_q == last_col) begin
              mr_d    = '0;
              state_d = S_MIN;
            end else begin
              dc_d = dc_q + COL_W'(1);
            end
          end else begin
            dr_d = dr_q + ROW_W'(1);
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_MIN: begin
        c_raddr = {last_col[0], mr_q};
        if (step_q == 3'd0) begin
          step_d = 3'd1;
        end else begin
          alu_ctl.load = (mr_q == '0);
          alu_ctl.cmp  = (mr_q != '0);
          if (mr_q == last_row) begin
            tc_d    = last_col;
            step_d  = 3'd2;
            state_d = S_TRACE;
          end else begin
            mr_d   = mr_q + ROW_W'(1);
            step_d = 3'd0;
          end
        end
      end
      S_TRACE: begin
        case (step_q)
          3'd2: begin
            prow_d = best_idx;
            step_d = 3'd0;
          end
          3'd0: begin
            pb_we = 1'b1;
            if (tc_q == '0) begin
              ec_d    = '0;
              state_d = S_EMIT_RD;
            end else begin
              step_d = 3'd1;
            end
          end
          default: begin
            prow_d = p_rdata;
            tc_d   = tc_q - COL_W'(1);
            step_d = 3'd0;
          end
        endcase
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_row_d  = pb_rdata;
        out_cost_d = best_cost;
        out_last_d = (ec_q == last_col);
        m_valid_d  = 1'b1;
        state_d    = S_EMIT_WT;
      end
      S_EMIT_WT: begin
        if (m_axis_tready) begin
          m_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = S_LOAD;
          end else begin
            ec_d    = ec_q + COL_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase

    // any register write resets the load position to zero
    if (cfg_wr) begin
      ld_row_d = '0;
      ld_col_d = '0;
      if (paddr[2]) begin
        cols_d = pwdata[CNT_W-1:0];
      end else begin
        rows_d = pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      rows_q    <= CNT_W'(1);
      cols_q    <= CNT_W'(1);
      ld_row_q  <= '0;
      ld_col_q  <= '0;
      dr_q      <= '0;
      dc_q      <= '0;
      mr_q      <= '0;
      tc_q      <= '0;
      ec_q      <= '0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      ld_row_q  <= ld_row_d;
      ld_col_q  <= ld_col_d;
      dr_q      <= dr_d;
      dc_q      <= dc_d;
      mr_q      <= mr_d;
      tc_q      <= tc_d;
      ec_q      <= ec_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prow_q     <= prow_d;
    out_last_q <= out_last_d;
    out_row_q  <= out_row_d;
    out_cost_q <= out_cost_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(32-COST_W-ROW_W){1'b0}}, out_cost_q, out_row_q};

  mmp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ROWS*MAX_COLS)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // two banks of column costs, bank chosen by column parity
  mmp_ram #(.WIDTH(COST_W), .DEPTH(2*MAX_ROWS)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  mmp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS*MAX_COLS)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i ({dr_q, dc_q}),
    .wdata_i (best_idx),
    .raddr_i ({prow_q, tc_q}),
    .rdata_o (p_rdata)
  );

  mmp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_COLS)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (pb_we),
    .waddr_i (tc_q),
    .wdata_i (prow_q),
    .raddr_i (ec_q),
    .rdata_o (pb_rdata)
  );

  mmp_alu u_alu (
    .clk_i       (clk_i),
    .ctl_i       (alu_ctl),
    .cost_i      (c_rdata),
    .idx_i       (alu_idx),
    .weight_i    (w_rdata),
    .best_cost_o (best_cost),
    .best_idx_o  (best_idx),
    .sum_o       (alu_sum)
  );

endmodule
`default_nettype wire

@@ design/mmp_ram.sv @@
`default_nettype none
module mmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/mmp_alu.sv @@
`default_nettype none
module mmp_alu (
  input  wire logic                                     clk_i,
  input  wire mmp_pkg::alu_ctl_t                        ctl_i,
  input  wire logic signed [mmp_pkg::COST_W-1:0]        cost_i,
  input  wire logic        [mmp_pkg::ROW_W-1:0]         idx_i,
  input  wire logic signed [mmp_pkg::WEIGHT_BITS-1:0]   weight_i,
  output logic signed      [mmp_pkg::COST_W-1:0]        best_cost_o,
  output logic             [mmp_pkg::ROW_W-1:0]         best_idx_o,
  output logic signed      [mmp_pkg::COST_W-1:0]        sum_o
);
  import mmp_pkg::*;

  logic signed [COST_W-1:0] best_q;
  logic        [ROW_W-1:0]  idx_q;
  logic signed [COST_W:0]   sum_wide;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load || (ctl_i.cmp && (cost_i < best_q))) begin
      best_q <= cost_i;
      idx_q  <= idx_i;
    end
  end

  // best + weight, saturated to the cost range
  always_comb begin
    sum_wide = {best_q[COST_W-1], best_q}
             + {{(COST_W+1-WEIGHT_BITS){weight_i[WEIGHT_BITS-1]}}, weight_i};
    if (sum_wide[COST_W] != sum_wide[COST_W-1]) begin
      sum_o = sum_wide[COST_W] ? COST_MIN : COST_MAX;
    end else begin
      sum_o = sum_wide[COST_W-1:0];
    end
  end

  assign best_cost_o = best_q;
  assign best_idx_o  = idx_q;

endmodule
`default_nettype wire

@@ test/min_path_checker.sv @@
`timescale 1ns / 1ps
module min_path_checker
  import mmp_pkg::*;
#(
  parameter logic [2:0] ROWS_ADDR = 3'd0,
  parameter logic [2:0] COLS_ADDR = 3'd4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  output int               mismatches,
  output int               outstanding
);

  typedef struct {
    logic [ROW_W-1:0]         row;
    logic signed [COST_W-1:0] cost;
    logic                     last;
  } path_step_t;

  localparam longint SUM_HI = COST_MAX;
  localparam longint SUM_LO = COST_MIN;

  path_step_t               steps_due[$];
  logic [CNT_W-1:0]         rows_reg;
  logic [CNT_W-1:0]         cols_reg;
  logic signed [WEIGHT_BITS-1:0] weights [MAX_ROWS*MAX_COLS];
  int                       fill_pos;

  // zero means one, anything above the maximum means the maximum
  function automatic int used_count(input logic [CNT_W-1:0] raw, input int maxv);
    if (raw == '0) return 1;
    if (int'(raw) > maxv) return maxv;
    return int'(raw);
  endfunction

  function automatic int sat_cost(input longint v);
    if (v > SUM_HI) return int'(SUM_HI);
    if (v < SUM_LO) return int'(SUM_LO);
    return int'(v);
  endfunction

  task automatic solve_min_path(input int rows, input int cols);
    int         cost_cur [MAX_ROWS];
    int         cost_nxt [MAX_ROWS];
    int         from_row [MAX_ROWS*MAX_COLS];
    int         trail [MAX_COLS];
    int         cand [3];
    int         r, c, k, t, best, bestv, total;
    path_step_t step;
    for (r = 0; r < rows; r++) cost_cur[r] = sat_cost(longint'(weights[r*cols]));
    for (c = 1; c < cols; c++) begin
      for (r = 0; r < rows; r++) begin
        cand[0] = (r + rows - 1) % rows;
        cand[1] = r;
        cand[2] = (r + 1) % rows;
        if (cand[0] > cand[1]) begin t = cand[0]; cand[0] = cand[1]; cand[1] = t; end
        if (cand[1] > cand[2]) begin t = cand[1]; cand[1] = cand[2]; cand[2] = t; end
        if (cand[0] > cand[1]) begin t = cand[0]; cand[0] = cand[1]; cand[1] = t; end
        // scan in ascending row order, strict compare: lowest row wins ties
        best  = cand[0];
        bestv = cost_cur[cand[0]];
        for (k = 1; k < 3; k++) begin
          if (cost_cur[cand[k]] < bestv) begin
            bestv = cost_cur[cand[k]];
            best  = cand[k];
          end
        end
        cost_nxt[r] = sat_cost(longint'(bestv) + longint'(weights[r*cols + c]));
        from_row[r*cols + c] = best;
      end
      cost_cur = cost_nxt;
    end
    best  = 0;
    total = cost_cur[0];
    for (r = 1; r < rows; r++) begin
      if (cost_cur[r] < total) begin
        total = cost_cur[r];
        best  = r;
      end
    end
    trail[cols-1] = best;
    for (c = cols - 1; c > 0; c--) trail[c-1] = from_row[trail[c]*cols + c];
    for (c = 0; c < cols; c++) begin
      step.row  = ROW_W'(trail[c]);
      step.cost = COST_W'(total);
      step.last = (c == cols - 1);
      steps_due.push_back(step);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    path_step_t  want;
    int          rows, cols;
    logic [31:0] reg_val;
    if (!rst_ni) begin
      rows_reg = CNT_W'(1);
      cols_reg = CNT_W'(1);
      fill_pos = 0;
      steps_due.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ROWS_ADDR) rows_reg = pwdata[CNT_W-1:0];
          else if (paddr == COLS_ADDR) cols_reg = pwdata[CNT_W-1:0];
          // any register write restarts the matrix load
          fill_pos = 0;
        end else begin
          reg_val = '0;
          if (paddr == ROWS_ADDR) reg_val[CNT_W-1:0] = rows_reg;
          else if (paddr == COLS_ADDR) reg_val[CNT_W-1:0] = cols_reg;
          if (prdata !== reg_val) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: readback at %0d: expected %h, got %h",
                       $time, paddr, reg_val, prdata);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        rows = used_count(rows_reg, MAX_ROWS);
        cols = used_count(cols_reg, MAX_COLS);
        if (fill_pos >= rows * cols) fill_pos = 0;
        weights[fill_pos] = s_axis_tdata[WEIGHT_BITS-1:0];
        fill_pos++;
        if (fill_pos == rows * cols) begin
          fill_pos = 0;
          solve_min_path(rows, cols);
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (steps_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: path item with none expected: tdata %h tlast %b",
                     $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = steps_due.pop_front();
          if (m_axis_tdata[4:0] !== want.row || m_axis_tdata[25:5] !== want.cost ||
              m_axis_tdata[31:26] !== 6'd0 || m_axis_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: path item: row exp %0d got %0d, cost exp %0d got %0d, ",
                        "pad got %h, last exp %b got %b"},
                       $time, want.row, m_axis_tdata[4:0], want.cost,
                       $signed(m_axis_tdata[25:5]), m_axis_tdata[31:26],
                       want.last, m_axis_tlast);
          end
        end
      end
      outstanding <= steps_due.size();
    end
  end

endmodule

@@ test/tb_matrix_min_path_wrap_dp.sv @@
`timescale 1ns / 1ps
module tb_matrix_min_path_wrap_dp;
  import mmp_pkg::*;

  localparam logic [2:0] ROWS_ADDR   = 3'd0;
  localparam logic [2:0] COLS_ADDR   = 3'd4;
  localparam int         ITEM_TARGET = 460;
  localparam int         STALL_LIMIT = 20000;
  localparam int         LONG_HOLD   = 800;
  localparam int         SETTLE      = 40;

  typedef enum int {W_ANY, W_TIES, W_EXTREME, W_FLAT} weight_mix_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int cells_sent   = 0;
  int burst_left   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  matrix_min_path_wrap_dp DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  min_path_checker #(
    .ROWS_ADDR (ROWS_ADDR),
    .COLS_ADDR (COLS_ADDR)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[matrix_min_path_wrap_dp] ERROR");
      $finish;
    end
  end

  // receiver: stretches of always-ready, random, sparse and periodic tready
  initial begin : drain
    int mode, span, i;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 120);
      for (i = 0; i < span; i++) begin
        @(posedge clk_i);
        // one long hold while the sender is offering an item to a busy block
        if (!held && results_seen >= 40 && s_axis_tvalid && !s_axis_tready) begin
          held = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
          default: m_axis_tready <= ((i % 7) < 4);
        endcase
      end
    end
  end

  function automatic int used_count(input int raw, input int maxv);
    if (raw == 0) return 1;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  task automatic push_cell(input logic [15:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    cells_sent++;
  endtask

  task automatic send_cells(input int count, input weight_mix_e mix);
    logic [15:0] fill;
    fill = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      case (mix)
        W_ANY:  push_cell(16'($urandom));
        W_TIES: push_cell(16'($urandom_range(0, 2)) - 16'd1);
        W_EXTREME:
          case ($urandom_range(0, 3))
            0:       push_cell(16'h7fff);
            1:       push_cell(16'h8000);
            2:       push_cell(16'h0000);
            default: push_cell(16'hffff);
          endcase
        default: push_cell(fill);
      endcase
    end
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper data bits are random; only the low six bits are stored
  task automatic set_shape(input int rows_raw, input int cols_raw);
    logic [31:0] data;
    data = $urandom;
    data[5:0] = 6'(rows_raw);
    apb_xfer(1'b1, ROWS_ADDR, data);
    data = $urandom;
    data[5:0] = 6'(cols_raw);
    apb_xfer(1'b1, COLS_ADDR, data);
    apb_xfer(1'b0, ROWS_ADDR, '0);
    apb_xfer(1'b0, COLS_ADDR, '0);
  endtask

  // wait for every expected path item, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    repeat (3) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int rows_raw, cols_raw, cells, mats;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1 out of reset: weight extremes
    push_cell(16'h7fff);
    push_cell(16'h8000);
    // two rows, all ties
    settle();
    set_shape(2, 2);
    repeat (4) push_cell(16'h0000);
    // three rows, tie between rows 1 and 2 as predecessors, all final rows tied
    settle();
    set_shape(3, 2);
    push_cell(16'd2); push_cell(16'd0);
    push_cell(16'd1); push_cell(16'd0);
    push_cell(16'd1); push_cell(16'd0);
    // four rows: cheapest path wraps from the last row to row 0
    settle();
    set_shape(4, 2);
    push_cell(16'd9); push_cell(16'd0);
    push_cell(16'd9); push_cell(16'd9);
    push_cell(16'd9); push_cell(16'd9);
    push_cell(16'd0); push_cell(16'd9);
    // partial matrix, dropped by the next register write
    settle();
    set_shape(2, 2);
    push_cell(16'h1234); push_cell(16'h8001); push_cell(16'h7ffe);

    // longest paths near the cost range limits, tallest column
    settle();
    set_shape(1, 32);
    repeat (32) push_cell(16'h7fff);
    settle();
    set_shape(1, 63);
    repeat (32) push_cell(16'h8000);
    settle();
    set_shape(32, 0);
    send_cells(32, W_ANY);
    settle();
    set_shape(40, 2);
    // second matrix waits at the input while the first is solved
    repeat (2) send_cells(64, W_TIES);

    while (cells_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          rows_raw = $urandom_range(0, 1) ? 32 : $urandom_range(33, 63);
          cols_raw = $urandom_range(0, 3);
        end
        1: begin
          cols_raw = $urandom_range(0, 1) ? 32 : $urandom_range(33, 63);
          rows_raw = $urandom_range(0, 3);
        end
        2: begin
          rows_raw = $urandom_range(0, 1);
          cols_raw = $urandom_range(0, 1);
        end
        default: begin
          rows_raw = $urandom_range(1, 6);
          cols_raw = $urandom_range(1, 6);
        end
      endcase
      settle();
      set_shape(rows_raw, cols_raw);
      cells = used_count(rows_raw, MAX_ROWS) * used_count(cols_raw, MAX_COLS);
      mats  = (cells > 40) ? 1 : $urandom_range(1, 3);
      repeat (mats) send_cells(cells, weight_mix_e'($urandom_range(0, 3)));
      if (cells > 1 && $urandom_range(0, 4) == 0)
        send_cells($urandom_range(1, cells - 1), W_ANY);
    end

    settle();
    if (mismatches == 0) begin
      $display("[matrix_min_path_wrap_dp] OK");
    end else begin
      $display("[matrix_min_path_wrap_dp] ERROR");
    end
    $finish;
  end

endmodule

@@ matrix_min_path_wrap_dp.f @@
design/mmp_pkg.sv
design/mmp_ram.sv
design/mmp_alu.sv
design/matrix_min_path_wrap_dp.sv
test/min_path_checker.sv
test/tb_matrix_min_path_wrap_dp.sv
